@@ sv/mf3_pkg.sv @@
// Package for the 3x3 median filter: queue sizing, register indexes, window and item types.
// No dependencies; imported by every module of the filter.
package mf3_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QLW         = $clog2(QUEUE_DEPTH + 1);
  localparam int QPW         = $clog2(QUEUE_DEPTH);

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } mf3_reg_t;

  // Nine window pixels, element k is position k of the 3x3 neighborhood
  typedef logic [8:0][7:0] pix9_t;

  // One classified pixel on its way from front to back
  typedef struct packed {
    pix9_t       win;
    logic [7:0]  px;
    logic [10:0] row;
    logic [10:0] col;
    logic        med;
    logic        border;
  } mf3_item_t;

endpackage

@@ sv/mf3_front.sv @@
// Front of the 3x3 median filter: position tracking, line stores, window, classification.
// Depends on mf3_pkg; pushes classified items into mf3_queue.
module mf3_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pos_clear,
  input  logic [CW-1:0]          wlast,
  input  logic [RW-1:0]          hlast,
  input  logic [7:0]             pixel,
  input  logic                   frame_start,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [mf3_pkg::QLW-1:0] q_level,
  output logic                   q_push,
  output mf3_pkg::mf3_item_t     q_item
);
  import mf3_pkg::*;

  logic [7:0]    upper_mem [MAX_WIDTH];
  logic [7:0]    middle_mem [MAX_WIDTH];

  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count;
  logic [RW-1:0] r_cur;
  logic [CW-1:0] c_cur;
  logic          accept;
  logic [QLW:0]  occ;

  logic          f1_valid;
  logic [7:0]    f1_px;
  logic [RW-1:0] f1_row;
  logic [CW-1:0] f1_col;
  logic          f1_med;
  logic          f1_border;
  logic [7:0]    up_rd;
  logic [7:0]    mid_rd;
  logic          byp;
  logic [7:0]    byp_top;
  logic [7:0]    byp_mid;
  logic [7:0]    top;
  logic [7:0]    mid;
  logic [5:0][7:0] window;

  // Leave room in the queue for the item already in the read stage
  assign occ      = {1'b0, q_level} + {{QLW{1'b0}}, f1_valid};
  assign in_ready = occ < (QLW + 1)'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  assign r_cur = frame_start ? '0 : row_count;
  assign c_cur = frame_start ? '0 : col_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (pos_clear) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (c_cur == wlast) begin
        col_count <= '0;
        row_count <= (r_cur == hlast) ? '0 : RW'(r_cur + 1'b1);
      end else begin
        col_count <= CW'(c_cur + 1'b1);
        row_count <= r_cur;
      end
    end
  end

  // Read stage: line store reads issued at accept, data valid in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_px     <= pixel;
      f1_row    <= r_cur;
      f1_col    <= c_cur;
      f1_med    <= (r_cur >= RW'(2)) && (c_cur >= CW'(2));
      f1_border <= (r_cur == '0) || (r_cur == hlast) || (c_cur == '0) || (c_cur == wlast);
      up_rd     <= upper_mem[c_cur];
      mid_rd    <= middle_mem[c_cur];
      // Forward the write in flight when it hits the same column
      byp       <= f1_valid && (f1_col == c_cur);
      byp_top   <= mid;
      byp_mid   <= f1_px;
    end
    if (f1_valid) begin
      upper_mem[f1_col]  <= mid;
      middle_mem[f1_col] <= f1_px;
    end
  end

  assign top = byp ? byp_top : up_rd;
  assign mid = byp ? byp_mid : mid_rd;

  // Window shifts by one column per pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (f1_valid) begin
      window[0] <= window[3];
      window[1] <= window[4];
      window[2] <= window[5];
      window[3] <= top;
      window[4] <= mid;
      window[5] <= f1_px;
    end
  end

  always_comb begin
    q_item        = '0;
    q_item.win[0] = window[0];
    q_item.win[1] = window[3];
    q_item.win[2] = top;
    q_item.win[3] = window[1];
    q_item.win[4] = window[4];
    q_item.win[5] = mid;
    q_item.win[6] = window[2];
    q_item.win[7] = window[5];
    q_item.win[8] = f1_px;
    q_item.px     = f1_px;
    q_item.row    = 11'(f1_row);
    q_item.col    = 11'(f1_col);
    q_item.med    = f1_med;
    q_item.border = f1_border;
  end

  // Drop pixels that yield no result
  assign q_push = f1_valid && (f1_med || f1_border);

endmodule

@@ sv/mf3_queue.sv @@
// Short flop-based queue between front and back of the median filter.
// Depends on mf3_pkg for the item type and depth.
module mf3_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  mf3_pkg::mf3_item_t      push_item,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output mf3_pkg::mf3_item_t      pop_item,
  output logic [mf3_pkg::QLW-1:0] level
);
  import mf3_pkg::*;

  mf3_item_t      slots [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QLW-1:0] count;
  logic           pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = count != '0;
  assign pop_item  = slots[rd_ptr];
  assign level     = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(rd_ptr + 1'b1);
      end
      unique case ({push, pop})
        2'b10:   count <= QLW'(count + 1'b1);
        2'b01:   count <= QLW'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ sv/mf3_back.sv @@
// Back of the median filter: three-stage sorting network and the output register.
// Depends on mf3_pkg; takes items from mf3_queue.
module mf3_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  mf3_pkg::mf3_item_t q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_value,
  output logic [10:0]        out_row,
  output logic [10:0]        out_col,
  output logic               is_border
);
  import mf3_pkg::*;

  function automatic pix9_t cmpx(pix9_t p, logic [3:0] a, logic [3:0] b);
    pix9_t q;
    q = p;
    if (p[a] > p[b]) begin
      q[a] = p[b];
      q[b] = p[a];
    end
    return q;
  endfunction

  function automatic pix9_t sort_a(pix9_t p);
    pix9_t q;
    q = p;
    q = cmpx(q, 4'd1, 4'd2); q = cmpx(q, 4'd4, 4'd5); q = cmpx(q, 4'd7, 4'd8);
    q = cmpx(q, 4'd0, 4'd1); q = cmpx(q, 4'd3, 4'd4); q = cmpx(q, 4'd6, 4'd7);
    q = cmpx(q, 4'd1, 4'd2); q = cmpx(q, 4'd4, 4'd5); q = cmpx(q, 4'd7, 4'd8);
    return q;
  endfunction

  function automatic pix9_t sort_b(pix9_t p);
    pix9_t q;
    q = p;
    q = cmpx(q, 4'd0, 4'd3); q = cmpx(q, 4'd5, 4'd8); q = cmpx(q, 4'd4, 4'd7);
    q = cmpx(q, 4'd3, 4'd6); q = cmpx(q, 4'd1, 4'd4); q = cmpx(q, 4'd2, 4'd5);
    q = cmpx(q, 4'd4, 4'd7);
    return q;
  endfunction

  function automatic pix9_t sort_c(pix9_t p);
    pix9_t q;
    q = p;
    q = cmpx(q, 4'd4, 4'd2); q = cmpx(q, 4'd6, 4'd4); q = cmpx(q, 4'd4, 4'd2);
    return q;
  endfunction

  logic      s1_valid, s2_valid, s3_valid;
  mf3_item_t s1_item, s2_item, s3_item;
  mf3_item_t s1_next, s2_next, s3_next;
  logic      s1_ready, s2_ready, s3_ready;
  logic      em_ready;
  logic      med_pend, bord_pend;
  logic [7:0]  em_median;
  logic [7:0]  em_px;
  logic [10:0] em_row;
  logic [10:0] em_col;

  assign em_ready = !(med_pend || bord_pend) || (out_ready && (med_pend ^ bord_pend));
  assign s3_ready = !s3_valid || em_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign q_ready  = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= q_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
    end
  end

  always_comb begin
    s1_next     = q_item;
    s1_next.win = sort_a(q_item.win);
    s2_next     = s1_item;
    s2_next.win = sort_b(s1_item.win);
    s3_next     = s2_item;
    s3_next.win = sort_c(s2_item.win);
  end

  always_ff @(posedge clk) begin
    if (s1_ready && q_valid) begin
      s1_item <= s1_next;
    end
    if (s2_ready && s1_valid) begin
      s2_item <= s2_next;
    end
    if (s3_ready && s2_valid) begin
      s3_item <= s3_next;
    end
  end

  // Output register: median first, then the border copy caused by the same input pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      med_pend  <= 1'b0;
      bord_pend <= 1'b0;
    end else if (em_ready) begin
      med_pend  <= s3_valid && s3_item.med;
      bord_pend <= s3_valid && s3_item.border;
    end else if (out_valid && out_ready) begin
      med_pend  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em_ready && s3_valid) begin
      em_median <= s3_item.win[4];
      em_px     <= s3_item.px;
      em_row    <= s3_item.row;
      em_col    <= s3_item.col;
    end
  end

  assign out_valid = med_pend || bord_pend;
  assign out_value = med_pend ? em_median : em_px;
  assign out_row   = med_pend ? 11'(em_row - 1'b1) : em_row;
  assign out_col   = med_pend ? 11'(em_col - 1'b1) : em_col;
  assign is_border = !med_pend;

endmodule

@@ sv/median_filter_3x3_unit.sv @@
// Top level of the 3x3 median filter: register port, front, queue and back.
// Depends on mf3_pkg, mf3_front, mf3_queue and mf3_back.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    pixel, frame_start
//   output    out_valid / out_ready  out_value, out_row, out_col, is_border
//   config    APB psel/penable/...   paddr (line_width at 0, frame_height at 4)
//
// One pixel per clock while the queue has room; two results for one pixel leave as two output transfers.
// Path: the line store read stage, the queue, three sorting network stages, then the
// output register that drives out_valid.
// The front stalls when the queue and the read stage together hold four items;
// the back stalls on out_ready.
// Reset is synchronous and clears control state; line stores are not cleared.
module median_filter_3x3_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel,
  input  logic        frame_start,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_value,
  output logic [10:0] out_row,
  output logic [10:0] out_col,
  output logic        is_border
);
  import mf3_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WDW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
  localparam int HDW = ($clog2(MAX_HEIGHT + 1) > 12) ? $clog2(MAX_HEIGHT + 1) : 12;

  localparam logic [11:0] LINE_WIDTH_RST   = 12'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

  logic [11:0]    line_width;
  logic [11:0]    frame_height;
  logic           cfg_write;
  logic [WDW-1:0] w_ext, w_eff;
  logic [HDW-1:0] h_ext, h_eff;
  logic [CW-1:0]  wlast;
  logic [RW-1:0]  hlast;

  logic           q_push;
  mf3_item_t      q_push_item;
  logic           q_pop_valid;
  logic           q_pop_ready;
  mf3_item_t      q_pop_item;
  logic [QLW-1:0] q_level;

  // Register port: writes land on the access phase, any write restarts the frame position
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_LINE_WIDTH:   line_width   <= pwdata[11:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[11:0];
        default:          line_width   <= line_width;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? {20'd0, frame_height} : {20'd0, line_width};

  // Clamp dimensions: zero counts as one, anything above the store size saturates
  assign w_ext = WDW'(line_width);
  assign h_ext = HDW'(frame_height);
  assign w_eff = (w_ext == '0) ? WDW'(1) : ((w_ext > WDW'(MAX_WIDTH)) ? WDW'(MAX_WIDTH) : w_ext);
  assign h_eff = (h_ext == '0) ? HDW'(1)
               : ((h_ext > HDW'(MAX_HEIGHT)) ? HDW'(MAX_HEIGHT) : h_ext);
  assign wlast = CW'(w_eff - 1'b1);
  assign hlast = RW'(h_eff - 1'b1);

  mf3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .pos_clear   (cfg_write),
    .wlast       (wlast),
    .hlast       (hlast),
    .pixel       (pixel),
    .frame_start (frame_start),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .q_level     (q_level),
    .q_push      (q_push),
    .q_item      (q_push_item)
  );

  mf3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_item  (q_pop_item),
    .level     (q_level)
  );

  mf3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_pop_valid),
    .q_ready   (q_pop_ready),
    .q_item    (q_pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .out_row   (out_row),
    .out_col   (out_col),
    .is_border (is_border)
  );

endmodule

@@ tb/tb_median_filter_3x3_unit.sv @@
`timescale 1ns / 100ps
// Testbench for median_filter_3x3_unit: streams raster frames through the pixel channel,
// predicts each filtered pixel in a behavioral model and checks every output transfer.
// Depends on mf3_pkg (window type, register indexes) and the median_filter_3x3_unit RTL.
module tb_median_filter_3x3_unit;
  import mf3_pkg::*;

  localparam int MAX_DIM       = 2048;
  localparam int CYCLE_LIMIT   = 1_200_000;
  // Pipeline plus four-entry queue is well under this; covers pixels that yield nothing
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {
    CONTENT_UNIFORM,
    CONTENT_NARROW,
    CONTENT_EXTREME
  } content_t;

  // One filtered pixel as it leaves the block
  typedef struct packed {
    logic [7:0]  value;
    logic [10:0] row;
    logic [10:0] col;
    logic        border;
  } pix_out_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  pixel;
  logic        frame_start;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_value;
  logic [10:0] out_row;
  logic [10:0] out_col;
  logic        is_border;

  // Idle insertion on both channels, and the long output hold-off counted by the sink
  bit          gaps_on = 1'b0;
  int          hold_off_left = 0;
  int          bad_results = 0;
  int unsigned cycle_count = 0;

  // Behavioral copy of the filter state
  logic [11:0] line_width_reg;
  logic [11:0] frame_height_reg;
  logic [7:0]  upper_line [MAX_DIM];
  logic [7:0]  middle_line [MAX_DIM];
  logic [7:0]  window_cols [6];
  int unsigned next_row;
  int unsigned next_col;
  pix_out_t    filtered_pixels [$];
  pix_out_t    want;

  median_filter_3x3_unit #(
    .MAX_WIDTH (MAX_DIM),
    .MAX_HEIGHT(MAX_DIM)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel      (pixel),
    .frame_start(frame_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_row    (out_row),
    .out_col    (out_col),
    .is_border  (is_border)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Zero means one, anything past the line store size saturates
  function automatic int unsigned clamp_size(logic [11:0] v);
    if (v == 12'd0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic int frame_pixels();
    return clamp_size(line_width_reg) * clamp_size(frame_height_reg);
  endfunction

  // Plain insertion sort; the middle element is the median whatever network the RTL uses
  function automatic logic [7:0] median_of_nine(pix9_t v);
    logic [7:0] t;
    for (int i = 1; i < 9; i++) begin
      for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
        t      = v[j];
        v[j]   = v[j-1];
        v[j-1] = t;
      end
    end
    return v[4];
  endfunction

  function automatic void reset_model();
    line_width_reg   = 12'd640;
    frame_height_reg = 12'd480;
    for (int i = 0; i < MAX_DIM; i++) begin
      upper_line[i]  = 8'd0;
      middle_line[i] = 8'd0;
    end
    for (int i = 0; i < 6; i++) window_cols[i] = 8'd0;
    next_row = 0;
    next_col = 0;
  endfunction

  // A size write takes effect at once and restarts the frame position
  function automatic void apply_size_reg(mf3_reg_t idx, logic [31:0] value);
    if (idx == REG_LINE_WIDTH) line_width_reg = value[11:0];
    else frame_height_reg = value[11:0];
    next_row = 0;
    next_col = 0;
  endfunction

  // Advance the model by one accepted pixel and queue the results it causes
  function automatic void filter_pixel(logic [7:0] px, logic fs);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    logic [7:0]  top;
    logic [7:0]  mid;
    pix9_t       nine;
    pix_out_t    res;
    w = clamp_size(line_width_reg);
    h = clamp_size(frame_height_reg);
    if (fs) begin
      next_row = 0;
      next_col = 0;
    end
    if (next_col >= w) next_col = 0;
    if (next_row >= h) next_row = 0;
    r   = next_row;
    c   = next_col;
    top = upper_line[c];
    mid = middle_line[c];
    // Window complete: the pixel up-left of this one gets its median now
    if (r >= 2 && c >= 2) begin
      nine = {window_cols[0], window_cols[1], window_cols[2], window_cols[3],
              window_cols[4], window_cols[5], top, mid, px};
      res.value  = median_of_nine(nine);
      res.row    = 11'(r - 1);
      res.col    = 11'(c - 1);
      res.border = 1'b0;
      filtered_pixels.push_back(res);
    end
    // Border copy follows the median when one pixel causes both
    if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
      res.value  = px;
      res.row    = 11'(r);
      res.col    = 11'(c);
      res.border = 1'b1;
      filtered_pixels.push_back(res);
    end
    window_cols[0] = window_cols[3];
    window_cols[1] = window_cols[4];
    window_cols[2] = window_cols[5];
    window_cols[3] = top;
    window_cols[4] = mid;
    window_cols[5] = px;
    upper_line[c]  = mid;
    middle_line[c] = px;
    next_col = c + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= h) next_row = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] make_pixel(content_t mode, logic [7:0] base);
    case (mode)
      CONTENT_NARROW:  return base + 8'($urandom_range(0, 3));
      CONTENT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:         return 8'($urandom);
    endcase
  endfunction

  // Offer one pixel, hold it until the transfer, then predict its results
  task automatic send_pixel(input logic [7:0] px, input logic fs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    pixel       <= px;
    frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    filter_pixel(px, fs);
  endtask

  // Send count pixels; restart_at puts a frame start in the middle of the run
  task automatic send_frame(input int count, input content_t mode, input bit mark_start,
                            input int restart_at);
    logic [7:0] base;
    base = 8'($urandom);
    for (int i = 0; i < count; i++) begin
      send_pixel(make_pixel(mode, base), (i == 0 && mark_start) || i == restart_at);
    end
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge
  task automatic write_size_reg(input mf3_reg_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_size_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Pause the sender until every predicted result is out and the pipeline is empty
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (filtered_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic resize(input logic [31:0] width, input logic [31:0] height);
    drain_results();
    write_size_reg(REG_LINE_WIDTH, width);
    write_size_reg(REG_FRAME_HEIGHT, height);
  endtask

  // Mostly real filter sizes, sometimes a strip narrower or shorter than the window
  function automatic logic [31:0] pick_size();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2);
    return $urandom_range(3, 14);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset size is 640x480: the first pixels are top-row copies
  task automatic test_power_on_size();
    gaps_on = 1'b0;
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b0);
  endtask

  // Smallest frame with an interior: one median, emitted ahead of the corner copy,
  // then one more pixel to show the wrap back to row 0 with no frame start
  task automatic test_smallest_window();
    logic [7:0] vals [9];
    vals = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'h00, 8'hFF, 8'h40};
    resize(3, 3);
    for (int i = 0; i < 9; i++) send_pixel(vals[i], i == 0);
    send_pixel(8'hA5, 1'b0);
  endtask

  // Frame start in the middle of a frame throws the position back to the origin
  task automatic test_frame_restart();
    resize(5, 4);
    gaps_on = 1'b1;
    send_frame(13, CONTENT_UNIFORM, 1'b1, -1);
    send_frame(3, CONTENT_EXTREME, 1'b1, -1);
  endtask

  // Zero sizes, tiny strips, junk above bit 11, and both sizes saturated
  task automatic test_size_extremes();
    gaps_on = 1'b1;
    resize(0, 0);
    send_frame(3, CONTENT_UNIFORM, 1'b1, -1);
    resize(1, 1);
    send_frame(2, CONTENT_EXTREME, 1'b0, -1);
    resize(2, 7);
    send_frame(frame_pixels() + 2, CONTENT_UNIFORM, 1'b1, -1);
    resize(7, 2);
    send_frame(frame_pixels() + 2, CONTENT_NARROW, 1'b0, -1);
    resize(32'hABCD_E006, 32'h0000_1004);
    send_frame(frame_pixels() + 2, CONTENT_UNIFORM, 1'b1, -1);
    // Saturated sizes: a width cut to 11 bits would start a new row on every pixel
    resize(2049, 4095);
    send_frame(40, CONTENT_UNIFORM, 1'b1, -1);
  endtask

  // Hold the output off long enough that the queue fills and the input stalls
  task automatic test_output_stall();
    resize(8, 6);
    gaps_on       = 1'b0;
    hold_off_left = 300;
    send_frame(48, CONTENT_UNIFORM, 1'b1, -1);
    drain_results();
  endtask

  // Random sizes and content; a few frames restarted early or cut short
  task automatic test_random_frames();
    int sent;
    int count;
    int restart;
    bit mark;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      if (sent == 0 || $urandom_range(0, 3) != 0) write_size_reg(REG_LINE_WIDTH, pick_size());
      if (sent == 0 || $urandom_range(0, 3) != 0) write_size_reg(REG_FRAME_HEIGHT, pick_size());
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        count   = frame_pixels();
        restart = -1;
        if ($urandom_range(0, 7) == 0) restart = $urandom_range(0, count - 1);
        if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count);
        mark = ($urandom_range(0, 4) != 0);
        send_frame(count, content_t'($urandom_range(0, 2)), mark, restart);
        sent += count;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Sink: a requested hold-off wins, otherwise random gaps between ready cycles
  initial begin : output_sink
    int ready_gap;
    ready_gap = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else if (ready_gap > 0) begin
        out_ready <= 1'b0;
        ready_gap--;
      end else begin
        out_ready <= 1'b1;
        ready_gap = pick_gap();
      end
    end
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (filtered_pixels.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("unexpected output: value %0d row %0d col %0d border %0b",
                   out_value, out_row, out_col, is_border);
      end else begin
        want = filtered_pixels.pop_front();
        if (out_value !== want.value || out_row !== want.row || out_col !== want.col ||
            is_border !== want.border) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("mismatch: expected value %0d row %0d col %0d border %0b,",
                     want.value, want.row, want.col, want.border,
                     " got value %0d row %0d col %0d border %0b",
                     out_value, out_row, out_col, is_border);
        end
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = 3'd0;
    pwdata      = 32'd0;
    in_valid    = 1'b0;
    pixel       = 8'd0;
    frame_start = 1'b0;
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_power_on_size();
    test_smallest_window();
    test_frame_restart();
    test_size_extremes();
    test_output_stall();
    test_random_frames();

    // Let stray outputs show up after the last prediction is consumed
    drain_results();
    if (bad_results == 0 && filtered_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
